// ===== rtl/cmfs_pkg.sv =====
`default_nettype none

package cmfs_pkg;

    localparam int DEF_COMPONENT_BITS      = 16;
    localparam int DEF_COORD_FRACTION_BITS = 16;

    typedef enum logic [2:0] {
        FACE_NEG_Z = 3'd0,
        FACE_POS_Z = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_X = 3'd3,
        FACE_NEG_Y = 3'd4,
        FACE_POS_X = 3'd5
    } t_face;

endpackage

`default_nettype wire

// ===== rtl/cmfs_in_if.sv =====
`default_nettype none

interface cmfs_in_if #(
    parameter int COMPONENT_BITS = cmfs_pkg::DEF_COMPONENT_BITS
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] dir_x;
    logic signed [COMPONENT_BITS-1:0] dir_y;
    logic signed [COMPONENT_BITS-1:0] dir_z;
    logic signed [COMPONENT_BITS-1:0] ddx_x;
    logic signed [COMPONENT_BITS-1:0] ddx_y;
    logic signed [COMPONENT_BITS-1:0] ddx_z;
    logic signed [COMPONENT_BITS-1:0] ddy_x;
    logic signed [COMPONENT_BITS-1:0] ddy_y;
    logic signed [COMPONENT_BITS-1:0] ddy_z;

    modport source (
        output valid, dir_x, dir_y, dir_z, ddx_x, ddx_y, ddx_z, ddy_x, ddy_y, ddy_z,
        input  ready
    );
    modport sink (
        input  valid, dir_x, dir_y, dir_z, ddx_x, ddx_y, ddx_z, ddy_x, ddy_y, ddy_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/cmfs_out_if.sv =====
`default_nettype none

interface cmfs_out_if #(
    parameter int COMPONENT_BITS      = cmfs_pkg::DEF_COMPONENT_BITS,
    parameter int COORD_FRACTION_BITS = cmfs_pkg::DEF_COORD_FRACTION_BITS
);
    logic                                valid;
    logic                                ready;
    logic [2:0]                          face;
    logic [COORD_FRACTION_BITS-1:0]      u_coord;
    logic [COORD_FRACTION_BITS-1:0]      v_coord;
    logic signed [COMPONENT_BITS-1:0]    ddx_first;
    logic signed [COMPONENT_BITS-1:0]    ddx_second;
    logic signed [COMPONENT_BITS-1:0]    ddy_first;
    logic signed [COMPONENT_BITS-1:0]    ddy_second;
    logic                                degenerate;

    modport source (
        output valid, face, u_coord, v_coord, ddx_first, ddx_second,
               ddy_first, ddy_second, degenerate,
        input  ready
    );
    modport sink (
        input  valid, face, u_coord, v_coord, ddx_first, ddx_second,
               ddy_first, ddy_second, degenerate,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/cube_map_face_select_unit.sv =====
`default_nettype none

// Cube map face select. Takes one direction vector and its two screen
// derivatives per beat, picks the major-axis face, and returns the face,
// rounded and saturated u/v in 0.COORD_FRACTION_BITS, the in-plane derivative
// components and a flag for the zero vector. Fully pipelined: one beat in and
// one beat out per clock while o_rsp.ready holds. The two restoring dividers
// resolve one quotient bit per stage. Each stage holds its beat independently,
// so bubbles are squeezed out under backpressure.
module cube_map_face_select_unit #(
    parameter int COMPONENT_BITS      = cmfs_pkg::DEF_COMPONENT_BITS,
    parameter int COORD_FRACTION_BITS = cmfs_pkg::DEF_COORD_FRACTION_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cmfs_in_if.sink     i_req,
    cmfs_out_if.source  o_rsp
);
    import cmfs_pkg::*;

    localparam int CB  = COMPONENT_BITS;
    localparam int FB  = COORD_FRACTION_BITS;
    localparam int NW  = CB + FB + 1;
    localparam int DS  = 3;
    localparam int NS  = FB + 5;
    localparam int OUT = NS - 1;

    // handshake chain
    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    assign w_rdy[NS] = o_rsp.ready;
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign i_req.ready = w_rdy[0];

    // stage 0: face select
    logic signed [CB+1:0] w_x, w_y, w_z, w_ax, w_ay;
    logic signed [CB+1:0] w_m, w_na, w_nb;
    t_face                n_face;
    logic signed [CB-1:0] n_dd [4];

    assign w_x  = (CB+2)'(i_req.dir_x);
    assign w_y  = (CB+2)'(i_req.dir_y);
    assign w_z  = (CB+2)'(i_req.dir_z);
    assign w_ax = w_x[CB+1] ? -w_x : w_x;
    assign w_ay = w_y[CB+1] ? -w_y : w_y;

    always_comb begin
        priority if (w_z <= -w_ax && w_z <= -w_ay) begin
            n_face = FACE_NEG_Z; w_m = -w_z; w_na = w_x;  w_nb = w_y;
        end else if (w_z >= w_ax && w_z >= w_ay) begin
            n_face = FACE_POS_Z; w_m = w_z;  w_na = w_x;  w_nb = -w_y;
        end else if (w_y >= w_ax) begin
            n_face = FACE_POS_Y; w_m = w_y;  w_na = w_x;  w_nb = w_z;
        end else if (w_x <= -w_ay) begin
            n_face = FACE_NEG_X; w_m = -w_x; w_na = w_y;  w_nb = w_z;
        end else if (w_y <= -w_ax) begin
            n_face = FACE_NEG_Y; w_m = -w_y; w_na = -w_x; w_nb = w_z;
        end else begin
            n_face = FACE_POS_X; w_m = w_x;  w_na = -w_y; w_nb = w_z;
        end
    end

    always_comb begin
        unique case (n_face)
            FACE_POS_Y, FACE_NEG_Y: begin
                n_dd[0] = i_req.ddx_x; n_dd[1] = i_req.ddx_z;
                n_dd[2] = i_req.ddy_x; n_dd[3] = i_req.ddy_z;
            end
            FACE_NEG_X, FACE_POS_X: begin
                n_dd[0] = i_req.ddx_y; n_dd[1] = i_req.ddx_z;
                n_dd[2] = i_req.ddy_y; n_dd[3] = i_req.ddy_z;
            end
            default: begin
                n_dd[0] = i_req.ddx_x; n_dd[1] = i_req.ddx_y;
                n_dd[2] = i_req.ddy_x; n_dd[3] = i_req.ddy_y;
            end
        endcase
    end

    // sideband carried through every stage
    t_face                r_face  [NS];
    logic                 r_degen [NS];
    logic signed [CB-1:0] r_dd    [NS][4];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_face[0]  <= n_face;
            r_degen[0] <= (w_m == '0);
            r_dd[0]    <= n_dd;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_face[k]  <= r_face[k-1];
                r_degen[k] <= r_degen[k-1];
                r_dd[k]    <= r_dd[k-1];
            end
        end
    end

    // stage 0 operands
    logic [CB-1:0]      r_a_m;
    logic signed [CB:0] r_a_nu, r_a_nv;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_a_m  <= w_m[CB-1:0];
            r_a_nu <= w_na[CB:0];
            r_a_nv <= w_nb[CB:0];
        end
    end

    // stage 1: m + n
    logic [CB-1:0]        r_b_m;
    logic signed [CB+1:0] r_b_su, r_b_sv;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_b_m  <= r_a_m;
            r_b_su <= $signed({2'b00, r_a_m}) + $signed({r_a_nu[CB], r_a_nu});
            r_b_sv <= $signed({2'b00, r_a_m}) + $signed({r_a_nv[CB], r_a_nv});
        end
    end

    // stage 2: clamp to [0, 2m], form (s << F) + m and 2m
    logic [CB:0]   w_twom, w_cu, w_cv;
    logic [NW-1:0] w_mext;
    logic [NW-1:0] r_c_nu, r_c_nv;
    logic [CB:0]   r_c_den;

    assign w_twom = {r_b_m, 1'b0};
    assign w_mext = {{(NW-CB){1'b0}}, r_b_m};

    always_comb begin
        priority if (r_b_su[CB+1])      w_cu = '0;
        else if (r_b_su[CB:0] > w_twom) w_cu = w_twom;
        else                            w_cu = r_b_su[CB:0];
        priority if (r_b_sv[CB+1])      w_cv = '0;
        else if (r_b_sv[CB:0] > w_twom) w_cv = w_twom;
        else                            w_cv = r_b_sv[CB:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_c_nu  <= {w_cu, {FB{1'b0}}} + w_mext;
            r_c_nv  <= {w_cv, {FB{1'b0}}} + w_mext;
            r_c_den <= w_twom;
        end
    end

    // stages 3 .. FB+3: dividers
    logic [FB:0] w_qu, w_qv;

    cmfs_coord_div #(
        .COMPONENT_BITS      (CB),
        .COORD_FRACTION_BITS (FB)
    ) u_div_u (
        .i_clk (i_clk),
        .i_en  (w_rdy[DS+FB:DS]),
        .i_num (r_c_nu),
        .i_den (r_c_den),
        .o_quo (w_qu)
    );

    cmfs_coord_div #(
        .COMPONENT_BITS      (CB),
        .COORD_FRACTION_BITS (FB)
    ) u_div_v (
        .i_clk (i_clk),
        .i_en  (w_rdy[DS+FB:DS]),
        .i_num (r_c_nv),
        .i_den (r_c_den),
        .o_quo (w_qv)
    );

    // output stage: saturate, zero-vector override
    localparam logic [FB-1:0] HALF = {1'b1, {(FB-1){1'b0}}};

    logic [FB-1:0] r_u, r_v_coord;

    always_ff @(posedge i_clk) begin
        if (w_rdy[OUT]) begin
            if (r_degen[OUT-1]) begin
                r_u       <= HALF;
                r_v_coord <= HALF;
            end else begin
                r_u       <= w_qu[FB] ? {FB{1'b1}} : w_qu[FB-1:0];
                r_v_coord <= w_qv[FB] ? {FB{1'b1}} : w_qv[FB-1:0];
            end
        end
    end

    assign o_rsp.valid      = r_v[OUT];
    assign o_rsp.face       = r_face[OUT];
    assign o_rsp.u_coord    = r_u;
    assign o_rsp.v_coord    = r_v_coord;
    assign o_rsp.ddx_first  = r_dd[OUT][0];
    assign o_rsp.ddx_second = r_dd[OUT][1];
    assign o_rsp.ddy_first  = r_dd[OUT][2];
    assign o_rsp.ddy_second = r_dd[OUT][3];
    assign o_rsp.degenerate = r_degen[OUT];

endmodule

`default_nettype wire

// ===== rtl/cmfs_coord_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per stage, MSB first.
module cmfs_coord_div #(
    parameter int COMPONENT_BITS      = cmfs_pkg::DEF_COMPONENT_BITS,
    parameter int COORD_FRACTION_BITS = cmfs_pkg::DEF_COORD_FRACTION_BITS,
    localparam int NW = COMPONENT_BITS + COORD_FRACTION_BITS + 1
) (
    input  wire logic                           i_clk,
    input  wire logic [COORD_FRACTION_BITS:0]   i_en,
    input  wire logic [NW-1:0]                  i_num,
    input  wire logic [COMPONENT_BITS:0]        i_den,
    output logic [COORD_FRACTION_BITS:0]        o_quo
);
    import cmfs_pkg::*;

    localparam int FB = COORD_FRACTION_BITS;

    logic [NW-1:0]             r_rem [FB+1];
    logic [COMPONENT_BITS:0]   r_den [FB+1];
    logic [FB:0]               r_quo [FB+1];

    for (genvar k = 0; k <= FB; k++) begin : g_stage
        localparam int BIT = FB - k;

        logic [NW-1:0]           w_rem_in;
        logic [COMPONENT_BITS:0] w_den_in;
        logic [FB:0]             w_quo_in;
        logic [NW-1:0]           w_sh;
        logic [NW:0]             w_diff;
        logic [NW-1:0]           n_rem;
        logic [FB:0]             n_quo;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_sh   = {{(NW-COMPONENT_BITS-1){1'b0}}, w_den_in} << BIT;
        assign w_diff = {1'b0, w_rem_in} - {1'b0, w_sh};

        always_comb begin
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            if (!w_diff[NW]) begin
                n_rem      = w_diff[NW-1:0];
                n_quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den_in;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[FB];

endmodule

`default_nettype wire
